// ----- sv/tts_pkg.sv -----
// Package for the two-threshold sparse spike selector.
// Holds the word types, register indexes, limits and reset values.
// No dependencies.
package tts_pkg;

    localparam int MAX_NEURONS = 4096;
    localparam int MAX_SLOTS   = 1024;

    localparam int NUM_W    = 13;   // num_neurons register
    localparam int SIZE_W   = 11;   // out_size register, list counters
    localparam int INDEX_W  = 12;   // item index within a frame
    localparam int SLOT_W   = 10;
    localparam int ID_W     = 16;
    localparam int RATIO_W  = 16;
    localparam int CFG_W    = 16;   // widest register
    localparam int VALUE_W  = 32;
    localparam int RATIO_SH = 15;   // near_ratio is Q1.15
    localparam int PROD_W   = VALUE_W + RATIO_W + 1;

    localparam logic [NUM_W-1:0]   RST_NUM_NEURONS = NUM_W'(4096);
    localparam logic [SIZE_W-1:0]  RST_OUT_SIZE    = SIZE_W'(256);
    localparam logic [ID_W-1:0]    RST_ID_OFFSET   = '0;
    localparam logic [RATIO_W-1:0] RST_NEAR_RATIO  = RATIO_W'(29491);

    typedef enum logic [1:0] {
        REG_NUM_NEURONS = 2'd0,
        REG_OUT_SIZE    = 2'd1,
        REG_ID_OFFSET   = 2'd2,
        REG_NEAR_RATIO  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic signed [VALUE_W-1:0] membrane;
        logic signed [VALUE_W-1:0] fire_level;
    } t_in_word;

    typedef struct packed {
        logic              placed;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   neuron_id;
        logic              is_spike;
        logic              frame_end;
        logic [SIZE_W-1:0] spike_count;
    } t_out_word;

endpackage

// ----- sv/two_threshold_sparse_spike_select.sv -----
// Two-threshold sparse spike selector, top level.
// Uses tts_pkg for word types, register indexes and limits.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one neuron
//   per word: membrane and fire_level, both signed Q16.16. A frame is
//   num_neurons words. Every accepted word yields exactly one result word on
//   the output channel (o_out_valid / i_out_stall / o_out_data), in order.
//   A result with placed set names a list slot (spikes fill from the front,
//   near-threshold or forced entries from the back) and the neuron id. The
//   result for the frame's last neuron has frame_end set and carries the
//   spike count; the list counters then clear for the next frame.
//   Throughput: one word per cycle while the receiver does not stall. An
//   accepted word passes through the stage 1 flag register, then the result
//   register. The first stage does the near-threshold multiply and compares;
//   the second stage holds the list counters and closes their update loop.
//   Reset (i_rst_n low, synchronous) empties the pipeline, clears the frame
//   counters and loads the register defaults. While the receiver stalls, the
//   result holds and the first stage still takes one more word; after that
//   o_in_stall rises. Write registers over i_cfg_* only when idle.
module two_threshold_sparse_spike_select
    import tts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_data
);

    // configuration
    logic [NUM_W-1:0]   r_num_neurons;
    logic [SIZE_W-1:0]  r_out_size;
    logic [ID_W-1:0]    r_id_offset;
    logic [RATIO_W-1:0] r_near_ratio;

    // frame state
    logic [INDEX_W-1:0] r_item_index, n_item_index;
    logic [SIZE_W-1:0]  r_front_count, n_front_count;
    logic [SIZE_W-1:0]  r_back_count, n_back_count;

    // stage 1: compare flags
    logic r_s1_valid;
    logic r_s1_near, r_s1_spike;
    logic n_s1_near, n_s1_spike;

    // stage 2: result register
    logic      r_out_valid;
    t_out_word r_out_data, n_out_data;

    logic in_take, s1_move, out_free;

    logic signed [PROD_W-1:0] thr_prod, mem_shift;

    logic [NUM_W-1:0]  num_eff, remaining;
    logic [SIZE_W-1:0] size_eff, used, free_slots, back_slot;
    logic              last, take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_neurons <= RST_NUM_NEURONS;
            r_out_size    <= RST_OUT_SIZE;
            r_id_offset   <= RST_ID_OFFSET;
            r_near_ratio  <= RST_NEAR_RATIO;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_NUM_NEURONS: r_num_neurons <= i_cfg_data[NUM_W-1:0];
                REG_OUT_SIZE:    r_out_size    <= i_cfg_data[SIZE_W-1:0];
                REG_ID_OFFSET:   r_id_offset   <= i_cfg_data[ID_W-1:0];
                REG_NEAR_RATIO:  r_near_ratio  <= i_cfg_data[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // near test: membrane * 2^15 > fire_level * near_ratio, exact
    always_comb begin
        thr_prod   = PROD_W'(i_in_data.fire_level) * $signed({1'b0, r_near_ratio});
        mem_shift  = PROD_W'(i_in_data.membrane) <<< RATIO_SH;
        n_s1_near  = mem_shift > thr_prod;
        n_s1_spike = i_in_data.membrane > i_in_data.fire_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
        if (in_take) begin
            r_s1_near  <= n_s1_near;
            r_s1_spike <= n_s1_spike;
        end
    end

    // list placement and frame bookkeeping
    always_comb begin
        if (r_num_neurons == '0) begin
            num_eff = NUM_W'(1);
        end else if (r_num_neurons > NUM_W'(MAX_NEURONS)) begin
            num_eff = NUM_W'(MAX_NEURONS);
        end else begin
            num_eff = r_num_neurons;
        end
        if (r_out_size == '0) begin
            size_eff = SIZE_W'(1);
        end else if (r_out_size > SIZE_W'(MAX_SLOTS)) begin
            size_eff = SIZE_W'(MAX_SLOTS);
        end else begin
            size_eff = r_out_size;
        end

        remaining = ({1'b0, r_item_index} < num_eff) ? num_eff - {1'b0, r_item_index}
                                                     : NUM_W'(1);
        last       = remaining == NUM_W'(1);
        used       = r_front_count + r_back_count;
        free_slots = size_eff - used;
        take       = (used < size_eff)
                   && (r_s1_near || remaining <= NUM_W'(free_slots));
        back_slot  = size_eff - SIZE_W'(1) - r_back_count;

        n_front_count = r_front_count;
        n_back_count  = r_back_count;
        n_out_data    = '0;

        if (take) begin
            n_out_data.placed    = 1'b1;
            n_out_data.neuron_id = r_id_offset + ID_W'(r_item_index);
            if (r_s1_spike) begin
                n_out_data.is_spike = 1'b1;
                n_out_data.slot     = r_front_count[SLOT_W-1:0];
                n_front_count       = r_front_count + SIZE_W'(1);
            end else begin
                n_out_data.slot = back_slot[SLOT_W-1:0];
                n_back_count    = r_back_count + SIZE_W'(1);
            end
        end

        if (last) begin
            n_out_data.frame_end   = 1'b1;
            n_out_data.spike_count = n_front_count;
            n_item_index           = '0;
            n_front_count          = '0;
            n_back_count           = '0;
        end else begin
            n_item_index = r_item_index + INDEX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_item_index  <= '0;
            r_front_count <= '0;
            r_back_count  <= '0;
        end else begin
            if (s1_move) begin
                r_out_valid   <= 1'b1;
                r_item_index  <= n_item_index;
                r_front_count <= n_front_count;
                r_back_count  <= n_back_count;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
        if (s1_move) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ----- sv/tts_checker.sv -----
// Port-level checks for the two-threshold sparse spike selector.
// Uses tts_pkg; bound to two_threshold_sparse_spike_select below.
module tts_checker
    import tts_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_data
);

    // unplaced words carry no slot, id or spike flag
    a_unplaced_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.placed |->
            o_out_data.slot == '0 && o_out_data.neuron_id == '0 && !o_out_data.is_spike)
        else $error("unplaced result word carries list data");

    a_count_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.frame_end |-> o_out_data.spike_count == '0)
        else $error("spike count shown before frame end");

    // a spike placed on the last word must be counted
    a_last_spike_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_end && o_out_data.placed && o_out_data.is_spike
            |-> o_out_data.spike_count != '0)
        else $error("spike on last word missing from count");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result word changed");

endmodule

bind two_threshold_sparse_spike_select tts_checker u_tts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
